### hdl/ffea_pkg.sv
// ffea_pkg: shared constants for the first-fit extent allocator.
// Field widths, function and status codes, parameter defaults.
// No dependencies.
package ffea_pkg;

  localparam int NUM_BLOCKS_DEF  = 64;
  localparam int BLOCK_BYTES_DEF = 4096;

  localparam int FUNC_W   = 2;
  localparam int SIZE_W   = 19;
  localparam int BLK_W    = 6;
  localparam int STATUS_W = 3;
  localparam int FREE_W   = 7;

  localparam logic [FUNC_W-1:0] FN_ALLOC  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_FREE   = 2'd1;
  localparam logic [FUNC_W-1:0] FN_CHECK  = 2'd2;
  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOSPACE  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOTALLOC = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ZERO     = 3'd4;

endpackage

### hdl/first_fit_extent_allocator.sv
// first_fit_extent_allocator: first-fit extent allocator with coalescing.
// Extent table in one synchronous RAM; sequencer reads, modifies, writes back.
// Depends on ffea_pkg.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid in_stall in_func                | request in
//          | in_size_bytes in_block_number            |
//  out     | out_valid out_stall out_status           | result out
//          | out_base_block out_free_count            |
//
// One request at a time. Allocate = size rounding (reciprocal multiply)
// + space check + table scan up to the hit (one entry per cycle)
// + shift of the entries above the split (one per cycle) + insert.
// Free = scan up to the hit + neighbor reads (S_NB1 to S_NB3) + shift down of the rest.
// Check = scan only. The single RAM port pair (one read, one write per cycle)
// sets the pace.
// Reset: rst_n synchronous; after reset the S_INIT state writes entry zero, in_stall
// high meanwhile. A finished result sits in the output register; a new request
// is taken while it waits; the next result waits for out_stall low.
module first_fit_extent_allocator
  import ffea_pkg::*;
#(
  parameter int NUM_BLOCKS  = NUM_BLOCKS_DEF,
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [SIZE_W-1:0]   in_size_bytes,
  input  logic [BLK_W-1:0]    in_block_number,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic [BLK_W-1:0]    out_base_block,
  output logic [FREE_W-1:0]   out_free_count
);

  localparam int IW  = $clog2(NUM_BLOCKS);      // table index
  localparam int CW  = $clog2(NUM_BLOCKS + 1);  // counts and lengths
  localparam int NW  = SIZE_W + 1;              // rounded size numerator
  // exact floor(num / BLOCK_BYTES) for num < 2**NW via reciprocal multiply
  localparam int SH  = NW + $clog2(BLOCK_BYTES);
  localparam int PW  = 2 * NW + 2;
  localparam longint unsigned RECIP =
    ((64'd1 << SH) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES);

  typedef struct packed {
    logic [IW-1:0] start;
    logic [CW-1:0] len;
    logic          fr;
  } ext_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DIV, S_FIT, S_SCAN, S_SHUP, S_INS,
    S_NB1, S_NB2, S_NB3, S_SHDN, S_DONE
  } state_t;

  // extent table RAM
  ext_t          mem [NUM_BLOCKS];
  ext_t          rd_q;
  logic [IW-1:0] rd_addr;
  logic          we;
  logic [IW-1:0] wa;
  ext_t          wd;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[rd_addr];
  end

  state_t                state_r, state_nxt;
  logic [FUNC_W-1:0]     func_r, func_nxt;
  logic [BLK_W-1:0]      blk_r, blk_nxt;
  logic [NW-1:0]         num_r, num_nxt;
  logic [NW-1:0]         need_r, need_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;     // valid extents (fill count)
  logic [CW-1:0]         free_r, free_nxt;   // free blocks
  logic [CW-1:0]         ra_r, ra_nxt;       // next read address
  logic [CW-1:0]         ri_r, ri_nxt;       // address of data in rd_q
  logic                  rv_r, rv_nxt;       // rd_q holds a requested read
  logic [CW-1:0]         fi_r, fi_nxt;       // matched entry
  ext_t                  fe_r, fe_nxt;
  logic                  sv_r, sv_nxt;       // successor is free
  logic [CW-1:0]         sl_r, sl_nxt;
  logic [1:0]            m_r, m_nxt;         // entries removed on merge
  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic [BLK_W-1:0]      start_r, start_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [BLK_W-1:0]      out_start_r, out_start_nxt;
  logic [FREE_W-1:0]     out_free_r, out_free_nxt;

  // match of the entry just read
  logic [NW-1:0] c_len, c_start, c_blk, c_end;
  logic          hit;
  always_comb begin
    c_len   = NW'(rd_q.len);
    c_start = NW'(rd_q.start);
    c_blk   = NW'(blk_r);
    c_end   = c_start + c_len;
    case (func_r)
      FN_ALLOC: hit = rd_q.fr && (c_len >= need_r);
      FN_FREE:  hit = !rd_q.fr && (c_start == c_blk);
      default:  hit = !rd_q.fr && (c_blk >= c_start) && (c_blk < c_end);
    endcase
  end

  // block count = (size + BLOCK_BYTES - 1) / BLOCK_BYTES
  logic [PW-1:0] prod;
  logic [NW-1:0] quo;
  always_comb begin
    prod = PW'(num_r) * PW'(RECIP);
    quo  = NW'(prod >> SH);
  end

  logic          pv;
  logic [CW-1:0] merged, k_pos;
  logic [1:0]    m_new;

  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    blk_nxt        = blk_r;
    num_nxt        = num_r;
    need_nxt       = need_r;
    cnt_nxt        = cnt_r;
    free_nxt       = free_r;
    ra_nxt         = ra_r;
    ri_nxt         = ri_r;
    rv_nxt         = rv_r;
    fi_nxt         = fi_r;
    fe_nxt         = fe_r;
    sv_nxt         = sv_r;
    sl_nxt         = sl_r;
    m_nxt          = m_r;
    status_nxt     = status_r;
    start_nxt      = start_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_start_nxt  = out_start_r;
    out_free_nxt   = out_free_r;
    we             = 1'b0;
    wa             = '0;
    wd             = '0;
    rd_addr        = ra_r[IW-1:0];
    pv             = 1'b0;
    merged         = '0;
    k_pos          = '0;
    m_new          = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_INIT: begin
        we        = 1'b1;
        wa        = '0;
        wd        = '{start: '0, len: CW'(NUM_BLOCKS), fr: 1'b1};
        cnt_nxt   = CW'(1);
        free_nxt  = CW'(NUM_BLOCKS);
        state_nxt = S_IDLE;
      end

      S_IDLE: begin
        if (in_valid) begin
          func_nxt  = in_func;
          blk_nxt   = in_block_number;
          start_nxt = '0;
          ra_nxt    = '0;
          rv_nxt    = 1'b0;
          case (in_func)
            FN_ALLOC: begin
              if (in_size_bytes == '0) begin
                status_nxt = ST_ZERO;
                state_nxt  = S_DONE;
              end else begin
                num_nxt   = NW'(in_size_bytes) + NW'(BLOCK_BYTES - 1);
                need_nxt  = '0;
                state_nxt = S_DIV;
              end
            end
            FN_FREE, FN_CHECK: begin
              if (NW'(in_block_number) >= NW'(NUM_BLOCKS)) begin
                status_nxt = ST_RANGE;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
              status_nxt = ST_RANGE;
              state_nxt  = S_DONE;
            end
          endcase
        end
      end

      S_DIV: begin
        need_nxt  = quo;
        state_nxt = S_FIT;
      end

      S_FIT: begin
        if (need_r > NW'(free_r)) begin
          status_nxt = ST_NOSPACE;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        if (rv_r && hit) begin
          fi_nxt = ri_r;
          fe_nxt = rd_q;
          rv_nxt = 1'b0;
          case (func_r)
            FN_ALLOC: begin
              we         = 1'b1;
              wa         = ri_r[IW-1:0];
              wd         = '{start: rd_q.start,
                             len: (c_len > need_r) ? need_r[CW-1:0] : rd_q.len,
                             fr: 1'b0};
              free_nxt   = free_r - need_r[CW-1:0];
              start_nxt  = BLK_W'(rd_q.start);
              status_nxt = ST_OK;
              if ((c_len > need_r) && (NW'(cnt_r) < NW'(NUM_BLOCKS))) begin
                ra_nxt    = cnt_r - CW'(1);
                state_nxt = S_SHUP;
              end else begin
                state_nxt = S_DONE;
              end
            end
            FN_FREE: begin
              state_nxt = S_NB1;
            end
            default: begin
              status_nxt = ST_OK;
              state_nxt  = S_DONE;
            end
          endcase
        end else if (!rv_r && (ra_r >= cnt_r)) begin
          status_nxt = (func_r == FN_ALLOC) ? ST_NOSPACE : ST_NOTALLOC;
          state_nxt  = S_DONE;
        end else if (ra_r < cnt_r) begin
          rv_nxt = 1'b1;
          ri_nxt = ra_r;
          ra_nxt = ra_r + CW'(1);
        end else begin
          rv_nxt = 1'b0;
        end
      end

      // open a slot at fi+1: move entries up, top first
      S_SHUP: begin
        if (rv_r) begin
          we = 1'b1;
          wa = IW'(ri_r + CW'(1));
          wd = rd_q;
        end
        if (ra_r > fi_r) begin
          rv_nxt = 1'b1;
          ri_nxt = ra_r;
          ra_nxt = ra_r - CW'(1);
        end else begin
          rv_nxt = 1'b0;
          if (!rv_r) begin
            state_nxt = S_INS;
          end
        end
      end

      S_INS: begin
        we        = 1'b1;
        wa        = IW'(fi_r + CW'(1));
        wd        = '{start: IW'(NW'(fe_r.start) + need_r),
                      len: CW'(NW'(fe_r.len) - need_r),
                      fr: 1'b1};
        cnt_nxt   = cnt_r + CW'(1);
        state_nxt = S_DONE;
      end

      S_NB1: begin
        rd_addr   = IW'(fi_r + CW'(1));
        state_nxt = S_NB2;
      end

      S_NB2: begin
        sv_nxt    = ((fi_r + CW'(1)) < cnt_r) && rd_q.fr;
        sl_nxt    = rd_q.len;
        rd_addr   = IW'(fi_r - CW'(1));
        state_nxt = S_NB3;
      end

      // rd_q holds the predecessor; write the merged extent
      S_NB3: begin
        pv       = (fi_r != '0) && rd_q.fr;
        merged   = fe_r.len + (sv_r ? sl_r : CW'(0));
        free_nxt = free_r + fe_r.len;
        m_new    = {1'b0, sv_r} + {1'b0, pv};
        we       = 1'b1;
        if (pv) begin
          wa    = IW'(fi_r - CW'(1));
          wd    = '{start: rd_q.start, len: rd_q.len + merged, fr: 1'b1};
          k_pos = fi_r;
        end else begin
          wa    = fi_r[IW-1:0];
          wd    = '{start: fe_r.start, len: merged, fr: 1'b1};
          k_pos = fi_r + CW'(1);
        end
        m_nxt      = m_new;
        ra_nxt     = k_pos + CW'(m_new);
        rv_nxt     = 1'b0;
        status_nxt = ST_OK;
        state_nxt  = (m_new != 2'd0) ? S_SHDN : S_DONE;
      end

      // close the gap: move entries down by m, bottom first
      S_SHDN: begin
        if (rv_r) begin
          we = 1'b1;
          wa = IW'(ri_r - CW'(m_r));
          wd = rd_q;
        end
        if (ra_r < cnt_r) begin
          rv_nxt = 1'b1;
          ri_nxt = ra_r;
          ra_nxt = ra_r + CW'(1);
        end else begin
          rv_nxt = 1'b0;
          if (!rv_r) begin
            cnt_nxt   = cnt_r - CW'(m_r);
            state_nxt = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_start_nxt  = (status_r == ST_OK) ? start_r : '0;
          out_free_nxt   = FREE_W'(free_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
      rv_r        <= 1'b0;
      cnt_r       <= CW'(1);
      free_r      <= CW'(NUM_BLOCKS);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rv_r        <= rv_nxt;
      cnt_r       <= cnt_nxt;
      free_r      <= free_nxt;
    end
    func_r       <= func_nxt;
    blk_r        <= blk_nxt;
    num_r        <= num_nxt;
    need_r       <= need_nxt;
    ra_r         <= ra_nxt;
    ri_r         <= ri_nxt;
    fi_r         <= fi_nxt;
    fe_r         <= fe_nxt;
    sv_r         <= sv_nxt;
    sl_r         <= sl_nxt;
    m_r          <= m_nxt;
    status_r     <= status_nxt;
    start_r      <= start_nxt;
    out_status_r <= out_status_nxt;
    out_start_r  <= out_start_nxt;
    out_free_r   <= out_free_nxt;
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_base_block  = out_start_r;
  assign out_free_count  = out_free_r;

endmodule

### hdl/ffea_chk.sv
// ffea_chk: port-level checks for first_fit_extent_allocator, plus bind.
// Depends on ffea_pkg.
module ffea_chk
  import ffea_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic [FUNC_W-1:0]   in_func,
  input logic [SIZE_W-1:0]   in_size_bytes,
  input logic [BLK_W-1:0]    in_block_number,
  input logic                out_valid,
  input logic                out_stall,
  input logic [STATUS_W-1:0] out_status,
  input logic [BLK_W-1:0]    out_base_block,
  input logic [FREE_W-1:0]   out_free_count
);

  // a held result keeps its fields
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_base_block) && $stable(out_free_count))
    else $error("result changed while stalled");

  // one request at a time: busy right after taking one
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while busy");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_ZERO)
    else $error("bad status code");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_base_block == '0)
    else $error("start block on failed request");

endmodule

bind first_fit_extent_allocator ffea_chk u_ffea_chk (.*);
